FILE: hdl/stlr_pkg.sv
// Shared widths, defaults and types for the stable timestamp label release block.
package stlr_pkg;

  localparam int unsigned DefPartitions = 16;
  localparam int unsigned DefCapacity   = 64;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PartW  = 4;
  localparam int unsigned CcW    = 5;
  localparam int unsigned DsW    = 16;

  localparam logic [CcW-1:0] CcReset = CcW'(16);
  localparam logic [DsW-1:0] DsReset = '0;
  localparam logic [DsW-1:0] PendMax = '1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_CLIENT_COUNT  = 1'b0,
    CFG_DELIVERY_SIZE = 1'b1
  } cfg_idx_t;

  // Input item function codes
  typedef enum logic [0:0] {
    FN_INSERT    = 1'b0,
    FN_HEARTBEAT = 1'b1
  } func_t;

  // One stored label
  typedef struct packed {
    logic        [TimeW-1:0]  ts;
    logic signed [ValueW-1:0] val;
  } label_t;

endpackage

FILE: hdl/stable_timestamp_label_release_top.sv
// Top level: sorted label store, heartbeat table and release sequencer.
//
// Labels live in a circular buffer memory kept sorted by time; heartbeats
// live in a second memory of PARTITIONS entries. One item is worked at a time
// and in_stall stays high until it is done. An insert shifts each stored label
// later than the new one up by one slot (a read and a write-back of the label
// memory each), then writes the new label. A full store gives one overflow
// transfer. A heartbeat writes its time, finds the stable minimum over the
// configured partitions, checks labels against it and releases those at or
// below it; out_stall can hold any result. The result register lets the block
// take a new item while a result waits.
module stable_timestamp_label_release_top #(
  parameter int unsigned PARTITIONS = stlr_pkg::DefPartitions,
  parameter int unsigned CAPACITY   = stlr_pkg::DefCapacity
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [stlr_pkg::PartW-1:0]          in_partition,
  input  logic [stlr_pkg::TimeW-1:0]          in_event_time,
  input  logic signed [stlr_pkg::ValueW-1:0]  in_label_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [stlr_pkg::ValueW-1:0]  out_released_value,
  output logic                                out_last,
  output logic                                out_batch_end,
  output logic                                out_overflow,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [0:0]                          cfg_index,
  input  logic [stlr_pkg::DsW-1:0]            cfg_data
);
  import stlr_pkg::*;

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned HAW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int unsigned PW  = $clog2(PARTITIONS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_OVF, S_INS_RD, S_INS_CMP, S_HB_WR, S_MIN_RD, S_MIN_CMP,
    S_CNT_RD, S_CNT_CMP, S_SUM, S_EM_RD, S_EM_OUT
  } state_t;

  state_t                 state_r;
  logic [CcW-1:0]         client_count_r;
  logic [DsW-1:0]         delivery_size_r;
  logic [DsW-1:0]         pending_r;
  logic [AW-1:0]          head_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          j_r;
  logic [CW-1:0]          k_r;
  logic [CW-1:0]          i_r;
  logic [PW-1:0]          ci_r;
  logic [PW-1:0]          n_eff;
  logic [TimeW-1:0]       min_r;
  logic                   close_r;
  logic [PartW-1:0]       part_r;
  logic [TimeW-1:0]       t_r;
  logic signed [ValueW-1:0] v_r;

  label_t                 lbl_mem [CAPACITY];
  label_t                 lbl_rd_r;
  logic [AW-1:0]          lbl_raddr;
  logic                   lbl_we;
  logic [AW-1:0]          lbl_waddr;
  label_t                 lbl_wdata;

  logic [TimeW-1:0]       hb_mem [PARTITIONS];
  logic [PARTITIONS-1:0]  hb_vld_r;
  logic [TimeW-1:0]       hb_rd_r;
  logic                   hb_rdv_r;
  logic [HAW-1:0]         hb_raddr;
  logic [HAW-1:0]         hb_waddr;
  logic                   hb_in_range;
  logic [TimeW-1:0]       hb_val;

  logic                   out_valid_r;
  logic signed [ValueW-1:0] out_val_r;
  logic                   out_last_r;
  logic                   out_bend_r;
  logic                   out_ovf_r;
  logic                   out_free;
  logic                   out_load;
  logic [DsW:0]           pend_sum;
  logic [DsW-1:0]         pend_sat;

  // Map a logical offset from the head to a physical buffer slot
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return AW'(s);
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = out_free && (state_r inside {S_OVF, S_EM_OUT});

  assign out_valid          = out_valid_r;
  assign out_released_value = out_val_r;
  assign out_last           = out_last_r;
  assign out_batch_end      = out_bend_r;
  assign out_overflow       = out_ovf_r;

  // Clamp the partition count to 1 .. PARTITIONS
  always_comb begin
    if (client_count_r == '0) n_eff = PW'(1);
    else if (32'(client_count_r) > PARTITIONS) n_eff = PW'(PARTITIONS);
    else n_eff = PW'(client_count_r);
  end

  assign hb_in_range = (32'(part_r) < PARTITIONS);
  assign hb_waddr    = HAW'(part_r);
  assign hb_raddr    = HAW'(ci_r);
  assign hb_val      = hb_rdv_r ? hb_rd_r : '0;

  assign pend_sum = (DsW+1)'(pending_r) + (DsW+1)'(k_r);
  assign pend_sat = pend_sum[DsW] ? PendMax : pend_sum[DsW-1:0];

  // Label memory address and write selection
  always_comb begin
    lbl_raddr = phys(head_r, k_r);
    lbl_we    = 1'b0;
    lbl_waddr = phys(head_r, j_r);
    lbl_wdata = '{ts: t_r, val: v_r};
    case (state_r)
      S_INS_RD:  lbl_raddr = phys(head_r, j_r - CW'(1));
      S_INS_CMP: begin
        lbl_raddr = phys(head_r, j_r - CW'(1));
        lbl_we    = 1'b1;
        if (lbl_rd_r.ts > t_r) lbl_wdata = lbl_rd_r;
      end
      S_EM_RD, S_EM_OUT: lbl_raddr = phys(head_r, i_r);
      default: ;
    endcase
    if (state_r == S_INS_RD && j_r == '0) lbl_we = 1'b1;
  end

  // Memories
  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
    lbl_rd_r <= lbl_mem[lbl_raddr];
    if (state_r == S_HB_WR && hb_in_range) hb_mem[hb_waddr] <= t_r;
    hb_rd_r  <= hb_mem[hb_raddr];
    hb_rdv_r <= hb_vld_r[hb_raddr];
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      client_count_r  <= CcReset;
      delivery_size_r <= DsReset;
      pending_r       <= '0;
      head_r          <= '0;
      count_r         <= '0;
      hb_vld_r        <= '0;
      out_valid_r     <= 1'b0;
      j_r             <= '0;
      k_r             <= '0;
      i_r             <= '0;
      ci_r            <= '0;
      close_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CLIENT_COUNT:  client_count_r  <= cfg_data[CcW-1:0];
          CFG_DELIVERY_SIZE: delivery_size_r <= cfg_data;
          default: ;
        endcase
      end
      // drop the result once transferred, unless a new one loads now
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            part_r <= in_partition;
            t_r    <= in_event_time;
            v_r    <= in_label_value;
            j_r    <= count_r;
            k_r    <= '0;
            i_r    <= '0;
            ci_r   <= '0;
            if (func_t'(in_func) == FN_HEARTBEAT) state_r <= S_HB_WR;
            else if (32'(count_r) >= CAPACITY) state_r <= S_OVF;
            else state_r <= S_INS_RD;
          end
        end
        S_OVF: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_val_r   <= '0;
            out_last_r  <= 1'b1;
            out_bend_r  <= 1'b0;
            out_ovf_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_INS_RD: begin
          if (j_r == '0) begin
            count_r <= count_r + CW'(1);
            state_r <= S_IDLE;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          // shift the later label up, or place the new one here
          if (lbl_rd_r.ts > t_r) begin
            j_r     <= j_r - CW'(1);
            state_r <= S_INS_RD;
          end else begin
            count_r <= count_r + CW'(1);
            state_r <= S_IDLE;
          end
        end
        S_HB_WR: begin
          if (hb_in_range) hb_vld_r[hb_waddr] <= 1'b1;
          state_r <= S_MIN_RD;
        end
        S_MIN_RD: state_r <= S_MIN_CMP;
        S_MIN_CMP: begin
          if (ci_r == '0 || hb_val < min_r) min_r <= hb_val;
          ci_r <= ci_r + PW'(1);
          if (ci_r + PW'(1) == n_eff) state_r <= S_CNT_RD;
          else state_r <= S_MIN_RD;
        end
        S_CNT_RD: begin
          if (k_r == count_r) state_r <= S_SUM;
          else state_r <= S_CNT_CMP;
        end
        S_CNT_CMP: begin
          if (lbl_rd_r.ts <= min_r) begin
            k_r     <= k_r + CW'(1);
            state_r <= S_CNT_RD;
          end else begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (k_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            if (pend_sat > delivery_size_r) begin
              close_r   <= 1'b1;
              pending_r <= '0;
            end else begin
              close_r   <= 1'b0;
              pending_r <= pend_sat;
            end
            state_r <= S_EM_RD;
          end
        end
        S_EM_RD: state_r <= S_EM_OUT;
        S_EM_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_val_r   <= lbl_rd_r.val;
            out_last_r  <= (i_r + CW'(1) == k_r);
            out_bend_r  <= (i_r + CW'(1) == k_r) && close_r;
            out_ovf_r   <= 1'b0;
            i_r         <= i_r + CW'(1);
            if (i_r + CW'(1) == k_r) begin
              head_r  <= phys(head_r, k_r);
              count_r <= count_r - k_r;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_EM_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY) else $error("label count above capacity");
  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_last_r && out_val_r == '0 && !out_bend_r)
    else $error("malformed overflow result");
  a_bend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bend_r |-> out_last_r) else $error("batch end off last result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_val_r))
    else $error("stalled result changed");

endmodule
